### sv/midi_event_stream_parser_defines.svh
// Assertion macros used by the checker file.
`ifndef MIDI_EVENT_STREAM_PARSER_DEFINES_SVH
`define MIDI_EVENT_STREAM_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MESP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MESP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/mesp_pkg.sv
package mesp_pkg;

	typedef enum logic [2:0] {
		KIND_NOTE_OFF  = 3'd0,
		KIND_NOTE_ON   = 3'd1,
		KIND_PROGRAM   = 3'd2,
		KIND_SET_MODE  = 3'd3,
		KIND_DELAY     = 3'd4,
		KIND_MUSIC_OFF = 3'd5
	} kind_t;

	localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
	localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
	localparam logic [7:0] STATUS_AFTERTCH  = 8'hA0;
	localparam logic [7:0] STATUS_CONTROL   = 8'hB0;
	localparam logic [7:0] STATUS_PROGRAM   = 8'hC0;
	localparam logic [7:0] STATUS_PRESSURE  = 8'hD0;
	localparam logic [7:0] STATUS_BEND      = 8'hE0;
	localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
	localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
	localparam logic [7:0] CTRL_RHYTHM_MODE = 8'h67;
	localparam logic [7:0] DATA_MASK        = 8'h7F;

	localparam int TDATA_W = 56;

endpackage

### sv/midi_event_stream_parser.sv
// A song item that yields a command goes from the input register, where it is accepted, to
// the output register, which loads the command when the output is not stalled.
// Throughput: one item per cycle while the output is not stalled; the parse state machine
// resolves each byte in a single pass between the input and result registers.
// Reset (arst_n low) returns the parser to the start delta with the delta discarded,
// and empties both the input and the result registers.
module midi_event_stream_parser
	import mesp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // song_byte[7:0]
	input  logic                 s_tuser,  // mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,  // channel[3:0], key[11:4], amount[19:12],
	                                       // delay_ticks[51:20], zero fill[55:52]
	output logic [2:0]           m_tuser   // kind
);

	typedef enum logic [3:0] {
		PH_DELTA,
		PH_EVENT,
		PH_AFTER_NOTE,
		PH_NOTE_VEL,
		PH_CTRL_NUM,
		PH_CTRL_VAL,
		PH_PROGRAM,
		PH_SYS_LEN,
		PH_SKIP
	} phase_t;

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q;
	logic [31:0] acc_q;
	logic [31:0] skip_q;
	logic [3:0]  run_ch_q;
	logic        run_on_q;
	logic [7:0]  held_byte_q;
	logic [3:0]  held_ch_q;
	logic        discard_q;

	logic [3:0]  ch_q;
	logic [7:0]  key_q;
	logic [7:0]  amount_q;
	logic [31:0] ticks_q;
	kind_t       kind_q;

	phase_t      n_phase;
	logic [31:0] n_acc;
	logic [31:0] n_skip;
	logic [3:0]  n_run_ch;
	logic        n_run_on;
	logic [7:0]  n_held_byte;
	logic [3:0]  n_held_ch;
	logic        n_discard;
	logic        emit;
	kind_t       n_kind;
	logic [3:0]  n_ch;
	logic [7:0]  n_key;
	logic [7:0]  n_amount;
	logic [31:0] n_ticks;

	logic        advance;
	logic [31:0] acc_shift;
	logic [31:0] len_plus1;
	logic [31:0] skip_dec;
	logic [3:0]  hi;

	assign advance   = !m_tvalid || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign acc_shift = {acc_q[24:0], byte_s1[6:0]};
	assign len_plus1 = acc_shift + 32'd1;
	assign skip_dec  = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
	assign hi        = byte_s1[7:4];

	always_comb begin
		n_phase     = phase_q;
		n_acc       = acc_q;
		n_skip      = skip_q;
		n_run_ch    = run_ch_q;
		n_run_on    = run_on_q;
		n_held_byte = held_byte_q;
		n_held_ch   = held_ch_q;
		n_discard   = discard_q;
		emit        = 1'b0;
		n_kind      = KIND_MUSIC_OFF;
		n_ch        = '0;
		n_key       = '0;
		n_amount    = '0;
		n_ticks     = '0;

		if (mode_s1) begin
			n_phase   = PH_DELTA;
			n_acc     = '0;
			n_skip    = '0;
			n_discard = 1'b1;
			emit      = 1'b1;
		end else begin
			unique case (phase_q)
				PH_DELTA: begin
					n_acc = acc_shift;
					if (!byte_s1[7]) begin
						n_acc   = '0;
						n_phase = PH_EVENT;
						if (discard_q) begin
							n_discard = 1'b0;
						end else if (acc_shift != 32'd0) begin
							emit    = 1'b1;
							n_kind  = KIND_DELAY;
							n_ticks = acc_shift;
						end
					end
				end
				PH_EVENT, PH_AFTER_NOTE: begin
					if (!byte_s1[7]) begin
						n_held_byte = byte_s1 & DATA_MASK;
						n_phase     = PH_NOTE_VEL;
					end else if (phase_q == PH_EVENT &&
							(hi == STATUS_NOTE_OFF[7:4] || hi == STATUS_NOTE_ON[7:4])) begin
						n_run_ch = byte_s1[3:0];
						n_run_on = (hi == STATUS_NOTE_ON[7:4]);
						n_phase  = PH_AFTER_NOTE;
					end else if (hi == STATUS_AFTERTCH[7:4] || hi == STATUS_BEND[7:4]) begin
						n_skip  = 32'd2;
						n_phase = PH_SKIP;
					end else if (hi == STATUS_PRESSURE[7:4]) begin
						n_skip  = 32'd1;
						n_phase = PH_SKIP;
					end else if (hi == STATUS_CONTROL[7:4]) begin
						n_held_ch = byte_s1[3:0];
						n_phase   = PH_CTRL_NUM;
					end else if (hi == STATUS_PROGRAM[7:4]) begin
						n_held_ch = byte_s1[3:0];
						n_phase   = PH_PROGRAM;
					end else if (byte_s1 == STATUS_SYSEX || byte_s1 == STATUS_SYSEX_END) begin
						n_acc   = '0;
						n_phase = PH_SYS_LEN;
					end else begin
						// Unknown system status, or a note status right after another one.
						n_phase   = PH_DELTA;
						n_acc     = '0;
						n_discard = 1'b0;
						emit      = 1'b1;
					end
				end
				PH_NOTE_VEL: begin
					n_phase  = PH_DELTA;
					emit     = 1'b1;
					n_kind   = (run_on_q && byte_s1 != 8'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
					n_ch     = run_ch_q;
					n_key    = held_byte_q;
					n_amount = byte_s1;
				end
				PH_CTRL_NUM: begin
					n_held_byte = byte_s1;
					n_phase     = PH_CTRL_VAL;
				end
				PH_CTRL_VAL: begin
					n_phase = PH_DELTA;
					if (held_byte_q == CTRL_RHYTHM_MODE) begin
						emit   = 1'b1;
						n_kind = KIND_SET_MODE;
						n_key  = byte_s1;
					end
				end
				PH_PROGRAM: begin
					n_phase = PH_DELTA;
					emit    = 1'b1;
					n_kind  = KIND_PROGRAM;
					n_ch    = held_ch_q;
					n_key   = byte_s1;
				end
				PH_SYS_LEN: begin
					n_acc = acc_shift;
					if (!byte_s1[7]) begin
						// A length of all ones wraps to a skip of zero bytes.
						n_skip  = len_plus1;
						n_acc   = '0;
						n_phase = (len_plus1 == 32'd0) ? PH_DELTA : PH_SKIP;
					end
				end
				PH_SKIP: begin
					n_skip = skip_dec;
					if (skip_dec == 32'd0) begin
						n_phase = PH_DELTA;
					end
				end
				default: begin
					n_phase = PH_DELTA;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			m_tvalid    <= 1'b0;
			phase_q     <= PH_DELTA;
			acc_q       <= '0;
			skip_q      <= '0;
			run_ch_q    <= '0;
			run_on_q    <= 1'b0;
			held_byte_q <= '0;
			held_ch_q   <= '0;
			discard_q   <= 1'b1;
			kind_q      <= KIND_NOTE_OFF;
			ch_q        <= '0;
			key_q       <= '0;
			amount_q    <= '0;
			ticks_q     <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_tvalid <= valid_s1 && emit;
				if (valid_s1) begin
					phase_q     <= n_phase;
					acc_q       <= n_acc;
					skip_q      <= n_skip;
					run_ch_q    <= n_run_ch;
					run_on_q    <= n_run_on;
					held_byte_q <= n_held_byte;
					held_ch_q   <= n_held_ch;
					discard_q   <= n_discard;
				end
				if (valid_s1 && emit) begin
					kind_q   <= n_kind;
					ch_q     <= n_ch;
					key_q    <= n_key;
					amount_q <= n_amount;
					ticks_q  <= n_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	assign m_tuser = kind_q;
	assign m_tdata = {4'd0, ticks_q, amount_q, key_q, ch_q};

endmodule

### sv/mesp_checker.sv
`include "midi_event_stream_parser_defines.svh"

module mesp_checker
	import mesp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [2:0]         m_tuser
);

	`MESP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

	`MESP_ASSERT_NOW(a_kind_range, clk, arst_n, m_tvalid, m_tuser <= KIND_MUSIC_OFF, "result kind out of range")

	`MESP_ASSERT_NOW(a_delay_fields, clk, arst_n, m_tvalid && m_tuser == KIND_DELAY, m_tdata[51:20] != 32'd0 && m_tdata[19:0] == 20'd0, "delay result with zero ticks or stray fields")

	`MESP_ASSERT_NOW(a_note_on_vel, clk, arst_n, m_tvalid && m_tuser == KIND_NOTE_ON, m_tdata[19:12] != 8'd0 && m_tdata[51:20] == 32'd0, "note on with zero velocity")

	`MESP_ASSERT_NOW(a_amount_notes, clk, arst_n, m_tvalid && m_tuser != KIND_NOTE_ON && m_tuser != KIND_NOTE_OFF, m_tdata[19:12] == 8'd0, "velocity on a non-note result")

endmodule

bind midi_event_stream_parser mesp_checker u_mesp_checker (.*);

### tb/sv/tb_midi_event_stream_parser.sv
module tb_midi_event_stream_parser;
	import mesp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SKIP_CAP     = 40;

	typedef enum logic [3:0] {
		ST_DELTA,
		ST_EVENT,
		ST_AFTER_NOTE,
		ST_NOTE_VEL,
		ST_CTRL_NUM,
		ST_CTRL_VAL,
		ST_PROGRAM,
		ST_SYS_LEN,
		ST_SKIP
	} parse_state_t;

	typedef struct {
		kind_t       kind;
		logic [3:0]  channel;
		logic [7:0]  key;
		logic [7:0]  amount;
		logic [31:0] ticks;
	} cmd_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic [2:0]         m_tuser;

	midi_event_stream_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Copy of the parser state kept by the testbench.
	parse_state_t parse_state;
	logic [31:0]  vlq_acc;
	logic [31:0]  skip_count;
	logic [3:0]   run_channel;
	logic         run_is_on;
	logic [7:0]   held_data;
	logic [7:0]   held_stat;
	logic         drop_delta;

	cmd_t pending_cmds[$];

	int  fail_count;
	int  items_sent;
	int  stops_sent;
	int  cmds_checked;
	int  cycles;
	bit  steady;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= steady || ($urandom_range(99) >= 19);
	end

	function automatic void push_cmd(kind_t k, logic [3:0] ch, logic [7:0] key,
	                                 logic [7:0] amt, logic [31:0] ticks);
		cmd_t c;
		c.kind = k;
		c.channel = ch;
		c.key = key;
		c.amount = amt;
		c.ticks = ticks;
		pending_cmds.push_back(c);
	endfunction

	function automatic void restart_song();
		parse_state = ST_DELTA;
		vlq_acc = '0;
		drop_delta = 1'b0;
		push_cmd(KIND_MUSIC_OFF, 4'd0, 8'd0, 8'd0, 32'd0);
	endfunction

	// Status bytes that are not note statuses, or a note status where none may stand.
	function automatic void other_status(logic [7:0] b);
		case (b & 8'hF0)
			STATUS_AFTERTCH: begin
				skip_count = 32'd2;
				parse_state = ST_SKIP;
			end
			STATUS_CONTROL: begin
				held_stat = b;
				parse_state = ST_CTRL_NUM;
			end
			STATUS_PROGRAM: begin
				held_stat = b;
				parse_state = ST_PROGRAM;
			end
			STATUS_PRESSURE: begin
				skip_count = 32'd1;
				parse_state = ST_SKIP;
			end
			STATUS_BEND: begin
				skip_count = 32'd2;
				parse_state = ST_SKIP;
			end
			STATUS_SYSEX: begin
				if (b == STATUS_SYSEX || b == STATUS_SYSEX_END) begin
					vlq_acc = '0;
					parse_state = ST_SYS_LEN;
				end else begin
					restart_song();
				end
			end
			default: restart_song();
		endcase
	endfunction

	function automatic void parse_byte(logic md, logic [7:0] b);
		logic [31:0] v;
		if (md) begin
			parse_state = ST_DELTA;
			vlq_acc = '0;
			skip_count = '0;
			drop_delta = 1'b1;
			push_cmd(KIND_MUSIC_OFF, 4'd0, 8'd0, 8'd0, 32'd0);
			return;
		end
		case (parse_state)
			ST_DELTA: begin
				vlq_acc = {vlq_acc[24:0], b[6:0]};
				if (!b[7]) begin
					v = vlq_acc;
					vlq_acc = '0;
					parse_state = ST_EVENT;
					if (drop_delta)
						drop_delta = 1'b0;
					else if (v != 0)
						push_cmd(KIND_DELAY, 4'd0, 8'd0, 8'd0, v);
				end
			end
			ST_EVENT: begin
				if (!b[7]) begin
					held_data = b;
					parse_state = ST_NOTE_VEL;
				end else if ((b & 8'hE0) == STATUS_NOTE_OFF) begin
					run_channel = b[3:0];
					run_is_on = ((b & 8'hF0) == STATUS_NOTE_ON);
					parse_state = ST_AFTER_NOTE;
				end else begin
					other_status(b);
				end
			end
			ST_AFTER_NOTE: begin
				if (!b[7]) begin
					held_data = b;
					parse_state = ST_NOTE_VEL;
				end else begin
					other_status(b);
				end
			end
			ST_NOTE_VEL: begin
				parse_state = ST_DELTA;
				// A note on with zero velocity is reported as a note off.
				push_cmd((run_is_on && b != 0) ? KIND_NOTE_ON : KIND_NOTE_OFF,
				         run_channel, held_data, b, 32'd0);
			end
			ST_CTRL_NUM: begin
				held_data = b;
				parse_state = ST_CTRL_VAL;
			end
			ST_CTRL_VAL: begin
				parse_state = ST_DELTA;
				if (held_data == CTRL_RHYTHM_MODE)
					push_cmd(KIND_SET_MODE, 4'd0, b, 8'd0, 32'd0);
			end
			ST_PROGRAM: begin
				parse_state = ST_DELTA;
				push_cmd(KIND_PROGRAM, held_stat[3:0], b, 8'd0, 32'd0);
			end
			ST_SYS_LEN: begin
				vlq_acc = {vlq_acc[24:0], b[6:0]};
				if (!b[7]) begin
					skip_count = vlq_acc + 32'd1;
					vlq_acc = '0;
					parse_state = (skip_count == 0) ? ST_DELTA : ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (skip_count != 0)
					skip_count = skip_count - 32'd1;
				if (skip_count == 0)
					parse_state = ST_DELTA;
			end
			default: parse_state = ST_DELTA;
		endcase
	endfunction

	// Entered and left at a falling edge.
	task automatic send_item(input logic md, input logic [7:0] b);
		while (!steady && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= md;
		do
			@(posedge clk);
		while (!s_tready);
		parse_byte(md, b);
		items_sent++;
		if (md)
			stops_sent++;
		@(negedge clk);
	endtask

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 20)
				$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_cmds
		cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				fail_count++;
				if (fail_count <= 20)
					$display("%0t: command with none expected, expected nothing, got kind %0d",
					         $time, m_tuser);
			end else begin
				want = pending_cmds.pop_front();
				cmds_checked++;
				report_field("kind", 32'(want.kind), 32'(m_tuser));
				report_field("channel", 32'(want.channel), 32'(m_tdata[3:0]));
				report_field("key", 32'(want.key), 32'(m_tdata[11:4]));
				report_field("amount", 32'(want.amount), 32'(m_tdata[19:12]));
				report_field("delay_ticks", want.ticks, m_tdata[51:20]);
			end
		end
	end

	task automatic test_start_delta();
		// A two-byte delta right after reset is dropped.
		send_item(1'b0, 8'h81);
		send_item(1'b0, 8'h00);
	endtask

	task automatic test_note_events();
		send_item(1'b0, STATUS_NOTE_ON);
		send_item(1'b0, 8'h3C);
		send_item(1'b0, 8'h7F);
		// Running status with zero velocity.
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h40);
		send_item(1'b0, 8'h00);
		// The longest delta wraps to all ones.
		repeat (4) send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h7F);
		send_item(1'b0, STATUS_NOTE_OFF | 8'h0F);
		send_item(1'b0, 8'h7F);
		send_item(1'b0, 8'hFF);
	endtask

	task automatic test_program_and_mode();
		send_item(1'b0, 8'h00);
		send_item(1'b0, STATUS_PROGRAM | 8'h0F);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b0, STATUS_CONTROL);
		send_item(1'b0, CTRL_RHYTHM_MODE);
		send_item(1'b0, 8'hFF);
	endtask

	task automatic test_sysex_skip();
		send_item(1'b0, 8'h00);
		send_item(1'b0, STATUS_SYSEX);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'h12);
	endtask

	task automatic test_restart_statuses();
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hF1);
		// After a restart the delta is kept.
		send_item(1'b0, 8'h03);
		send_item(1'b0, STATUS_NOTE_ON);
		send_item(1'b0, STATUS_NOTE_OFF);
	endtask

	task automatic test_stop();
		send_item(1'b1, 8'($urandom_range(255)));
	endtask

	task automatic send_random_delta();
		int r;
		int n;
		r = $urandom_range(99);
		if (r < 50) begin
			send_item(1'b0, 8'h00);
			return;
		end
		n = (r < 80) ? 1 : (r < 95) ? 2 : 5;
		repeat (n - 1) send_item(1'b0, {1'b1, 7'($urandom_range(127))});
		send_item(1'b0, {1'b0, 7'($urandom_range(127))});
	endtask

	function automatic logic [7:0] random_velocity();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'($urandom_range(255, 128));
		return 8'($urandom_range(127));
	endfunction

	task automatic play_random_event();
		int r;
		int len;
		logic [3:0] ch;
		logic [7:0] st;
		r = $urandom_range(99);
		ch = 4'($urandom_range(15));
		if (r >= 88 && r <= 90) begin
			send_item(1'b1, 8'($urandom_range(255)));
			return;
		end
		send_random_delta();
		if (r < 30) begin
			st = ($urandom_range(1) ? STATUS_NOTE_ON : STATUS_NOTE_OFF) | {4'd0, ch};
			send_item(1'b0, st);
			send_item(1'b0, 8'($urandom_range(127)));
			send_item(1'b0, random_velocity());
		end else if (r < 45) begin
			send_item(1'b0, 8'($urandom_range(127)));
			send_item(1'b0, random_velocity());
		end else if (r < 53) begin
			send_item(1'b0, STATUS_PROGRAM | {4'd0, ch});
			send_item(1'b0, 8'($urandom_range(255)));
		end else if (r < 65) begin
			send_item(1'b0, STATUS_CONTROL | {4'd0, ch});
			send_item(1'b0, ($urandom_range(9) < 6) ? CTRL_RHYTHM_MODE
			                                         : 8'($urandom_range(127)));
			send_item(1'b0, 8'($urandom_range(255)));
		end else if (r < 70) begin
			send_item(1'b0, STATUS_AFTERTCH | {4'd0, ch});
			repeat (2) send_item(1'b0, 8'($urandom_range(127)));
		end else if (r < 74) begin
			send_item(1'b0, STATUS_PRESSURE | {4'd0, ch});
			send_item(1'b0, 8'($urandom_range(127)));
		end else if (r < 79) begin
			send_item(1'b0, STATUS_BEND | {4'd0, ch});
			repeat (2) send_item(1'b0, 8'($urandom_range(127)));
		end else if (r < 85) begin
			send_item(1'b0, $urandom_range(1) ? STATUS_SYSEX : STATUS_SYSEX_END);
			if ($urandom_range(9) == 0) begin
				// A length of all ones wraps so that nothing is skipped.
				repeat (4) send_item(1'b0, 8'hFF);
				send_item(1'b0, DATA_MASK);
			end else begin
				len = $urandom_range(15);
				send_item(1'b0, 8'(len));
				repeat (len + 1) send_item(1'b0, 8'($urandom_range(255)));
			end
		end else if (r < 88) begin
			do
				st = 8'($urandom_range(255, 241));
			while (st == STATUS_SYSEX_END);
			send_item(1'b0, st);
		end else if (r < 96) begin
			repeat ($urandom_range(3, 1)) send_item(1'b0, 8'($urandom_range(255)));
		end else begin
			send_item(1'b0, STATUS_NOTE_ON | {4'd0, ch});
			send_item(1'b0, 8'($urandom_range(255, 128)));
		end
	endtask

	task automatic test_random_song();
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			steady = (items_sent - start >= 600 && items_sent - start < 900);
			play_random_event();
			// Noise can open a sysex with a huge length; a stop clears it.
			if (parse_state == ST_SYS_LEN || skip_count > SKIP_CAP)
				send_item(1'b1, 8'($urandom_range(255)));
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		steady = 1'b0;
		fail_count = 0;
		items_sent = 0;
		stops_sent = 0;
		cmds_checked = 0;
		cycles = 0;
		parse_state = ST_DELTA;
		vlq_acc = '0;
		skip_count = '0;
		run_channel = '0;
		run_is_on = 1'b0;
		held_data = '0;
		held_stat = '0;
		drop_delta = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_start_delta();
		test_note_events();
		test_program_and_mode();
		test_sysex_skip();
		test_restart_statuses();
		test_stop();
		test_random_song();

		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d song items including %0d stop requests; %0d decoded commands compared.",
		         items_sent, stops_sent, cmds_checked);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
